### rtl/core/crcse_pkg.sv
// Shared types, constants and the byte fold function of the CRC-32 stream engine.
`default_nettype none

package crcse_pkg;

    localparam logic [31:0] CRC_POLY_REFLECTED = 32'hEDB88320;
    localparam logic [2:0]  MAX_ITEM_BYTES     = 3'd4;
    localparam int          BYTES_PER_ITEM     = 4;

    typedef struct packed {
        logic        first;
        logic [31:0] seed;
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        last;
    } crcse_item_t;

    function automatic logic [31:0] fold_byte(input logic [31:0] crc_in,
                                              input logic [7:0]  byte_in);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, byte_in};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY_REFLECTED;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

### rtl/core/crc32_stream_engine_core.sv
// Top level of the reflected CRC-32 stream engine.
// Computes IEEE 802.3 CRC-32 (reflected, final inversion) over a stream of requests of one to
// four bytes each, byte 0 in bits 7:0 folded first. A request with first_item loads the running
// register with ~seed, so seed 0 starts a fresh CRC; a request with last_item yields one result,
// the inverted running register, on crc_value. Byte counts above four act as four. One request
// is accepted every cycle while the FIFO has room. The back end folds the counted bytes of a
// request into the running CRC, and a QUEUE_DEPTH-entry FIFO between front and back absorbs
// output stalls. A request is written into the FIFO at its accepting edge; once it is popped and
// folded, a last request registers its result on crc_value and raises out_valid.
`default_nettype none

module crc32_stream_engine_core
    import crcse_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        first_item,
    input  wire logic [31:0] seed,
    input  wire logic [31:0] data_bytes,
    input  wire logic [2:0]  byte_count,
    input  wire logic        last_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      crc_value
);

    crcse_item_t push_item;
    crcse_item_t pop_item;
    logic        push_valid, push_ready;
    logic        pop_valid, pop_ready;

    crcse_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .first_item (first_item),
        .seed       (seed),
        .data_bytes (data_bytes),
        .byte_count (byte_count),
        .last_item  (last_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    crcse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    crcse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .crc_value (crc_value)
    );

endmodule

`default_nettype wire

### rtl/core/crcse_front.sv
// Front end: accepts requests, saturates the byte count and drops items that do nothing.
`default_nettype none

module crcse_front
    import crcse_pkg::*;
(
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        first_item,
    input  wire logic [31:0] seed,
    input  wire logic [31:0] data_bytes,
    input  wire logic [2:0]  byte_count,
    input  wire logic        last_item,
    output logic             push_valid,
    input  wire logic        push_ready,
    output crcse_item_t      push_item
);

    logic [2:0] nbytes;
    logic       no_op;

    always_comb
    begin
        nbytes = (byte_count > MAX_ITEM_BYTES) ? MAX_ITEM_BYTES : byte_count;
        no_op  = !first_item && !last_item && (nbytes == 3'd0);

        push_item.first  = first_item;
        push_item.seed   = seed;
        push_item.data   = data_bytes;
        push_item.nbytes = nbytes;
        push_item.last   = last_item;
    end

    assign in_ready   = push_ready;
    assign push_valid = in_valid && !no_op;

endmodule

`default_nettype wire

### rtl/core/crcse_queue.sv
// Small FIFO that decouples the front end from the CRC back end.
`default_nettype none

module crcse_queue
    import crcse_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push_valid,
    output logic              push_ready,
    input  wire crcse_item_t  push_item,
    output logic              pop_valid,
    input  wire logic         pop_ready,
    output crcse_item_t       pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    crcse_item_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    always_comb
    begin
        push_ready  = (count_reg != FULL_CNT);
        pop_valid   = (count_reg != '0);
        pop_item    = mem[rd_ptr_reg];
        do_wr       = push_valid && push_ready;
        do_rd       = pop_valid && pop_ready;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/crcse_back.sv
// Back end: folds queued bytes into the running CRC and registers finished results.
`default_nettype none

module crcse_back
    import crcse_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         pop_valid,
    output logic              pop_ready,
    input  wire crcse_item_t  pop_item,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [31:0]       crc_value
);

    logic [31:0] crc_reg, crc_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] result_reg, result_next;
    logic [31:0] crc_work;
    logic        take;

    always_comb
    begin
        pop_ready = !pop_item.last || !out_valid_reg || out_ready;
        take      = pop_valid && pop_ready;

        crc_work = pop_item.first ? ~pop_item.seed : crc_reg;
        for (int i = 0; i < BYTES_PER_ITEM; i++)
        begin
            if (3'(i) < pop_item.nbytes)
            begin
                crc_work = fold_byte(crc_work, pop_item.data[8*i +: 8]);
            end
        end

        crc_next       = take ? crc_work : crc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        result_next    = result_reg;
        if (take && pop_item.last)
        begin
            out_valid_next = 1'b1;
            result_next    = ~crc_work;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign crc_value = result_reg;

endmodule

`default_nettype wire
